[rtl/mnp_pkg.sv]
// ---------------------------------------------------------------------------
// mnp_pkg: shared types, constants and helpers for mesh_normalize_place
// Holds the sequencer states, the micro-op table of the shared multiplier,
// the divider request type and the saturation helpers.
// ---------------------------------------------------------------------------
package mnp_pkg;

	localparam int MAX_VERTICES_DEF    = 65536;
	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int TRIG_FRAC_BITS      = 14;
	localparam int SUM_W               = 48;
	localparam int DVD_W               = 56;
	localparam int DVS_W               = 33;
	localparam int OPA_W               = 33;
	localparam int PROD_W              = 66;
	localparam int ACC_W               = 67;
	localparam int NUM_UOPS            = 27;
	localparam int UOP_W               = 5;
	localparam int PADDR_W             = 5;

	typedef enum logic [2:0] {
		REG_POS_X     = 3'd0,
		REG_POS_Y     = 3'd1,
		REG_POS_Z     = 3'd2,
		REG_TARGET_H  = 3'd3,
		REG_ROLL_SC   = 3'd4,
		REG_PITCH_SC  = 3'd5,
		REG_YAW_SC    = 3'd6,
		REG_NONE      = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_CENTER,
		ST_MUL,
		ST_ACC,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		BSEL_SCALE,
		BSEL_COS,
		BSEL_SIN,
		BSEL_NSIN
	} bsel_t;

	typedef enum logic [1:0] {
		ANG_ROLL,
		ANG_PITCH,
		ANG_YAW,
		ANG_NONE
	} angle_t;

	typedef struct packed {
		logic [2:0] a_idx;
		bsel_t      bsel;
		angle_t     ang;
		logic       first;
		logic       last;
		logic       to_temp;
		logic       commit;
		logic [2:0] dst;
		logic       narrow;
		logic       scale_op;
	} uop_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	// Micro-op list: three scale products, then six rotation pairs
	// (vertex roll, pitch, yaw, then normal roll, pitch, yaw), four products each.
	function automatic uop_t uop(input logic [UOP_W-1:0] step);
		uop_t       u;
		logic [4:0] k;
		logic [2:0] p;
		logic [1:0] q;
		logic [2:0] base;
		logic [2:0] ia;
		logic [2:0] ib;
		u          = '0;
		u.bsel     = BSEL_SCALE;
		u.ang      = ANG_NONE;
		k          = step - 5'd3;
		p          = k[4:2];
		base       = (p >= 3'd3) ? 3'd3 : 3'd0;
		q          = (p >= 3'd3) ? 2'(p - 3'd3) : p[1:0];
		ia         = 3'd0;
		ib         = 3'd0;
		if (step < 5'd3) begin
			u.a_idx    = step[2:0];
			u.first    = 1'b1;
			u.last     = 1'b1;
			u.dst      = step[2:0];
			u.scale_op = 1'b1;
		end else begin
			case (q)
				2'd0: begin
					u.ang = ANG_ROLL;
					ia    = 3'd1;
					ib    = 3'd2;
				end
				2'd1: begin
					u.ang = ANG_PITCH;
					ia    = 3'd2;
					ib    = 3'd0;
				end
				default: begin
					u.ang = ANG_YAW;
					ia    = 3'd0;
					ib    = 3'd1;
				end
			endcase
			u.narrow = (p >= 3'd3);
			case (k[1:0])
				2'd0: begin
					u.a_idx = base + ia;
					u.bsel  = BSEL_COS;
					u.first = 1'b1;
				end
				2'd1: begin
					u.a_idx   = base + ib;
					u.bsel    = BSEL_SIN;
					u.last    = 1'b1;
					u.to_temp = 1'b1;
				end
				2'd2: begin
					u.a_idx = base + ib;
					u.bsel  = BSEL_COS;
					u.first = 1'b1;
				end
				default: begin
					u.a_idx  = base + ia;
					u.bsel   = BSEL_NSIN;
					u.last   = 1'b1;
					u.commit = 1'b1;
					u.dst    = base + ib;
				end
			endcase
		end
		return u;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic [31:0] r;
		if (v > ACC_W'(signed'(33'sh0_7FFF_FFFF)))
			r = 32'h7FFF_FFFF;
		else if (v < -ACC_W'(signed'(34'sh0_8000_0000)))
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic [31:0] sat16(input logic signed [ACC_W-1:0] v);
		logic [31:0] r;
		if (v > ACC_W'(signed'(17'sh0_7FFF)))
			r = 32'h0000_7FFF;
		else if (v < -ACC_W'(signed'(18'sh0_8000)))
			r = 32'hFFFF_8000;
		else
			r = {{16{v[15]}}, v[15:0]};
		return r;
	endfunction

endpackage

[rtl/mesh_normalize_place.sv]
// ---------------------------------------------------------------------------
// mesh_normalize_place: centers, scales, rotates and places mesh vertices
// Two-pass mesh normalizer built around one shared multiplier and one
// bit-serial divider under a small sequencer.
// ---------------------------------------------------------------------------
// Usage: stream the mesh once with action 0 (measure), then again with
// action 1 (transform). Measure transactions produce no result; each
// transform transaction produces exactly one result transaction.
// Input channel: in_valid / in_stall; the block holds in_stall high while it
// works on an item. Output channel: out_valid / out_stall with one output
// register, so a finished result may wait while the next item is taken.
// Sequence: a measure item updates the pass state when it is accepted. A
// transform item passes the accepting cycle, a centering state, 27
// multiply-accumulate products on the shared multiplier, each through a
// multiply state and an accumulate state, and a final state that loads the output register. The
// first transform item of a pass with a nonzero tally also runs up to four
// 56-step divisions (three centroid axes and the scale, which is skipped
// when the height span is not positive) before centering.
// A stalled result holds the finished item in the sequencer until the
// output register frees up. Reset clears the measure state, sets scale 1.0
// and loads the register reset values. Configuration goes through an
// APB-style port and must only be written while the block is idle.
// ---------------------------------------------------------------------------
module mesh_normalize_place #(
	parameter int MAX_VERTICES    = mnp_pkg::MAX_VERTICES_DEF,
	parameter int COORD_FRAC_BITS = mnp_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mnp_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic signed [31:0]          vert_x,
	input  logic signed [31:0]          vert_y,
	input  logic signed [31:0]          vert_z,
	input  logic signed [15:0]          norm_x,
	input  logic signed [15:0]          norm_y,
	input  logic signed [15:0]          norm_z,
	// output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [31:0]          out_x,
	output logic signed [31:0]          out_y,
	output logic signed [31:0]          out_z,
	output logic signed [15:0]          out_norm_x,
	output logic signed [15:0]          out_norm_y,
	output logic signed [15:0]          out_norm_z,
	output logic                        degenerate
);

	localparam int TALLY_W = $clog2(MAX_VERTICES + 1);
	localparam int SUM_W   = mnp_pkg::SUM_W;
	localparam int OPA_W   = mnp_pkg::OPA_W;
	localparam int ACC_W   = mnp_pkg::ACC_W;
	localparam int DVD_W   = mnp_pkg::DVD_W;
	localparam int DVS_W   = mnp_pkg::DVS_W;
	localparam logic [31:0] SCALE_ONE = 32'(1) << COORD_FRAC_BITS;
	localparam logic [mnp_pkg::UOP_W-1:0] LAST_UOP = mnp_pkg::UOP_W'(mnp_pkg::NUM_UOPS - 1);

	// configuration registers
	logic [31:0] pos_x_q, pos_y_q, pos_z_q;
	logic [30:0] target_height_q;
	logic [31:0] roll_q, pitch_q, yaw_q;
	mnp_pkg::cfg_reg_t cfg_idx;

	// measure and pass state
	logic [SUM_W-1:0]   sum_x_q, sum_y_q, sum_z_q;
	logic signed [31:0] lowest_y_q, highest_y_q;
	logic [TALLY_W-1:0] tally_q;
	logic [31:0]        centroid_q [3];
	logic [31:0]        scale_q;
	logic               in_trans_q;
	logic               degen_q;

	// sequencer and datapath
	mnp_pkg::state_t           state_q, state_d;
	logic [1:0]                div_idx_q;
	logic                      div_neg_q;
	logic [mnp_pkg::UOP_W-1:0] step_q;
	logic signed [OPA_W-1:0]   r_q [6];
	logic [31:0]               t_q;
	logic signed [mnp_pkg::PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]   acc_q;

	// output register
	logic        out_valid_q;
	logic [31:0] out_x_q, out_y_q, out_z_q;
	logic [15:0] out_nx_q, out_ny_q, out_nz_q;
	logic        out_degen_q;

	logic in_acc, out_acc, out_free, cfg_wr;

	assign pready   = 1'b1;
	assign cfg_idx  = mnp_pkg::cfg_reg_t'(paddr[mnp_pkg::PADDR_W-1:2]);
	assign cfg_wr   = psel && penable && pwrite;
	assign in_stall = (state_q != mnp_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	// ---------------- configuration port ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q         <= '0;
			pos_y_q         <= '0;
			pos_z_q         <= '0;
			target_height_q <= 31'd65536;
			roll_q          <= 32'd16384;
			pitch_q         <= 32'd16384;
			yaw_q           <= 32'd16384;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				mnp_pkg::REG_POS_X:    pos_x_q         <= pwdata;
				mnp_pkg::REG_POS_Y:    pos_y_q         <= pwdata;
				mnp_pkg::REG_POS_Z:    pos_z_q         <= pwdata;
				mnp_pkg::REG_TARGET_H: target_height_q <= pwdata[30:0];
				mnp_pkg::REG_ROLL_SC:  roll_q          <= pwdata;
				mnp_pkg::REG_PITCH_SC: pitch_q         <= pwdata;
				mnp_pkg::REG_YAW_SC:   yaw_q           <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			mnp_pkg::REG_POS_X:    prdata = pos_x_q;
			mnp_pkg::REG_POS_Y:    prdata = pos_y_q;
			mnp_pkg::REG_POS_Z:    prdata = pos_z_q;
			mnp_pkg::REG_TARGET_H: prdata = {1'b0, target_height_q};
			mnp_pkg::REG_ROLL_SC:  prdata = roll_q;
			mnp_pkg::REG_PITCH_SC: prdata = pitch_q;
			mnp_pkg::REG_YAW_SC:   prdata = yaw_q;
			default:               prdata = '0;
		endcase
	end

	// ---------------- measure pass ----------------
	// A measure item during a transform pass restarts from cleared bounds.
	logic [SUM_W-1:0]   m_sx, m_sy, m_sz;
	logic signed [31:0] m_lo, m_hi;
	logic [TALLY_W-1:0] m_tally;
	logic               m_take;

	always_comb begin
		m_sx    = in_trans_q ? '0 : sum_x_q;
		m_sy    = in_trans_q ? '0 : sum_y_q;
		m_sz    = in_trans_q ? '0 : sum_z_q;
		m_lo    = in_trans_q ? 32'sh7FFF_FFFF : lowest_y_q;
		m_hi    = in_trans_q ? 32'sh8000_0000 : highest_y_q;
		m_tally = in_trans_q ? '0 : tally_q;
		m_take  = (m_tally < TALLY_W'(MAX_VERTICES));
	end

	// ---------------- divider requests ----------------
	logic [SUM_W-1:0]   div_sum;
	logic [SUM_W-1:0]   div_mag;
	logic signed [32:0] span;
	logic               span_pos;
	mnp_pkg::div_req_t  div_req;
	logic               div_done;
	logic [DVD_W-1:0]   div_quo;
	logic [31:0]        cen_res;

	always_comb begin
		unique case (div_idx_q)
			2'd0:    div_sum = sum_x_q;
			2'd1:    div_sum = sum_y_q;
			default: div_sum = sum_z_q;
		endcase
	end

	assign div_mag  = div_sum[SUM_W-1] ? (~div_sum + 1'b1) : div_sum;
	assign span     = {highest_y_q[31], highest_y_q} - {lowest_y_q[31], lowest_y_q};
	assign span_pos = !span[32] && (span != '0);

	always_comb begin
		div_req.start = (state_q == mnp_pkg::ST_DIV_START) &&
			!((div_idx_q == 2'd3) && !span_pos);
		if (div_idx_q == 2'd3) begin
			div_req.dividend = DVD_W'(target_height_q) << COORD_FRAC_BITS;
			div_req.divisor  = span[DVS_W-1:0];
		end else begin
			div_req.dividend = DVD_W'(div_mag);
			div_req.divisor  = DVS_W'(tally_q);
		end
	end

	// Apply the sign and saturate a centroid quotient to 32 bits.
	always_comb begin
		if (div_neg_q) begin
			if (div_quo > DVD_W'(33'h0_8000_0000))
				cen_res = 32'h8000_0000;
			else
				cen_res = ~div_quo[31:0] + 1'b1;
		end else begin
			if (div_quo > DVD_W'(32'h7FFF_FFFF))
				cen_res = 32'h7FFF_FFFF;
			else
				cen_res = div_quo[31:0];
		end
	end

	mnp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ---------------- shared multiplier ----------------
	mnp_pkg::uop_t           u;
	logic [31:0]             sc_sel;
	logic signed [15:0]      sin_v, cos_v;
	logic signed [OPA_W-1:0] op_b;
	logic signed [ACC_W-1:0] acc_sum;
	logic signed [ACC_W-1:0] acc_shr;
	logic [31:0]             wb_val;

	assign u = mnp_pkg::uop(step_q);

	always_comb begin
		case (u.ang)
			mnp_pkg::ANG_ROLL:  sc_sel = roll_q;
			mnp_pkg::ANG_PITCH: sc_sel = pitch_q;
			default:            sc_sel = yaw_q;
		endcase
		sin_v = sc_sel[31:16];
		cos_v = sc_sel[15:0];
		case (u.bsel)
			mnp_pkg::BSEL_SCALE: op_b = OPA_W'(signed'({1'b0, scale_q}));
			mnp_pkg::BSEL_COS:   op_b = OPA_W'(cos_v);
			mnp_pkg::BSEL_SIN:   op_b = OPA_W'(sin_v);
			default:             op_b = -OPA_W'(sin_v);
		endcase
	end

	assign acc_sum = u.first ? ACC_W'(prod_s1) : (acc_q + ACC_W'(prod_s1));
	assign acc_shr = u.scale_op ? (acc_sum >>> COORD_FRAC_BITS)
		: (acc_sum >>> mnp_pkg::TRIG_FRAC_BITS);
	assign wb_val  = u.narrow ? mnp_pkg::sat16(acc_shr) : mnp_pkg::sat32(acc_shr);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mnp_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mnp_pkg::ST_IDLE: begin
				if (in_acc && action) begin
					if (in_trans_q || (tally_q == '0))
						state_d = mnp_pkg::ST_CENTER;
					else
						state_d = mnp_pkg::ST_DIV_START;
				end
			end
			mnp_pkg::ST_DIV_START: begin
				state_d = div_req.start ? mnp_pkg::ST_DIV_WAIT : mnp_pkg::ST_CENTER;
			end
			mnp_pkg::ST_DIV_WAIT: begin
				if (div_done)
					state_d = (div_idx_q == 2'd3) ? mnp_pkg::ST_CENTER
						: mnp_pkg::ST_DIV_START;
			end
			mnp_pkg::ST_CENTER: state_d = mnp_pkg::ST_MUL;
			mnp_pkg::ST_MUL:    state_d = mnp_pkg::ST_ACC;
			mnp_pkg::ST_ACC: begin
				state_d = (step_q == LAST_UOP) ? mnp_pkg::ST_FIN : mnp_pkg::ST_MUL;
			end
			mnp_pkg::ST_FIN: begin
				if (out_free)
					state_d = mnp_pkg::ST_IDLE;
			end
			default: state_d = mnp_pkg::ST_IDLE;
		endcase
	end

	// Pass state: measure updates, centroid and scale, degenerate flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q       <= '0;
			sum_y_q       <= '0;
			sum_z_q       <= '0;
			lowest_y_q    <= 32'sh7FFF_FFFF;
			highest_y_q   <= 32'sh8000_0000;
			tally_q       <= '0;
			centroid_q[0] <= '0;
			centroid_q[1] <= '0;
			centroid_q[2] <= '0;
			scale_q       <= SCALE_ONE;
			in_trans_q    <= 1'b0;
			degen_q       <= 1'b0;
			div_idx_q     <= '0;
			div_neg_q     <= 1'b0;
		end else begin
			if (in_acc && !action) begin
				// measure: clear on a new pass, drop once the tally saturates
				if (in_trans_q)
					degen_q <= 1'b0;
				in_trans_q <= 1'b0;
				sum_x_q    <= m_take ? m_sx + SUM_W'(vert_x) : m_sx;
				sum_y_q    <= m_take ? m_sy + SUM_W'(vert_y) : m_sy;
				sum_z_q    <= m_take ? m_sz + SUM_W'(vert_z) : m_sz;
				lowest_y_q <= (m_take && (vert_y < m_lo)) ? vert_y : m_lo;
				highest_y_q <= (m_take && (vert_y > m_hi)) ? vert_y : m_hi;
				tally_q    <= m_take ? m_tally + 1'b1 : m_tally;
			end else if (in_acc && action && !in_trans_q) begin
				// first transform item of a pass
				in_trans_q <= 1'b1;
				div_idx_q  <= '0;
				if (tally_q == '0) begin
					centroid_q[0] <= '0;
					centroid_q[1] <= '0;
					centroid_q[2] <= '0;
					scale_q       <= SCALE_ONE;
					degen_q       <= 1'b1;
				end
			end
			if (state_q == mnp_pkg::ST_DIV_START) begin
				div_neg_q <= div_sum[SUM_W-1];
				if (!div_req.start) begin
					scale_q <= SCALE_ONE;
					degen_q <= 1'b1;
				end
			end
			if ((state_q == mnp_pkg::ST_DIV_WAIT) && div_done) begin
				if (div_idx_q == 2'd3)
					scale_q <= (div_quo > DVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
						: div_quo[31:0];
				else
					centroid_q[div_idx_q] <= cen_res;
				div_idx_q <= div_idx_q + 1'b1;
			end
		end
	end

	// Operand file, products and accumulator.
	always_ff @(posedge clk) begin
		if (in_acc && action) begin
			r_q[0] <= OPA_W'(vert_x);
			r_q[1] <= OPA_W'(vert_y);
			r_q[2] <= OPA_W'(vert_z);
			r_q[3] <= OPA_W'(norm_x);
			r_q[4] <= OPA_W'(norm_y);
			r_q[5] <= OPA_W'(norm_z);
		end
		if (state_q == mnp_pkg::ST_CENTER) begin
			r_q[0] <= r_q[0] - OPA_W'(signed'(centroid_q[0]));
			r_q[1] <= r_q[1] - OPA_W'(signed'(centroid_q[1]));
			r_q[2] <= r_q[2] - OPA_W'(signed'(centroid_q[2]));
		end
		if (state_q == mnp_pkg::ST_MUL)
			prod_s1 <= r_q[u.a_idx] * op_b;
		if (state_q == mnp_pkg::ST_ACC) begin
			acc_q <= acc_sum;
			if (u.last) begin
				if (u.to_temp) begin
					t_q <= wb_val;
				end else begin
					r_q[u.dst] <= OPA_W'(signed'(wb_val));
					if (u.commit)
						r_q[u.a_idx] <= OPA_W'(signed'(t_q));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= '0;
		else if (state_q == mnp_pkg::ST_CENTER)
			step_q <= '0;
		else if (state_q == mnp_pkg::ST_ACC)
			step_q <= step_q + 1'b1;
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if ((state_q == mnp_pkg::ST_FIN) && out_free)
			out_valid_q <= 1'b1;
		else if (out_acc)
			out_valid_q <= 1'b0;
	end

	// Add the placement offset and load the finished transaction.
	always_ff @(posedge clk) begin
		if ((state_q == mnp_pkg::ST_FIN) && out_free) begin
			out_x_q     <= mnp_pkg::sat32(ACC_W'(r_q[0]) + ACC_W'(signed'(pos_x_q)));
			out_y_q     <= mnp_pkg::sat32(ACC_W'(r_q[1]) + ACC_W'(signed'(pos_y_q)));
			out_z_q     <= mnp_pkg::sat32(ACC_W'(r_q[2]) + ACC_W'(signed'(pos_z_q)));
			out_nx_q    <= r_q[3][15:0];
			out_ny_q    <= r_q[4][15:0];
			out_nz_q    <= r_q[5][15:0];
			out_degen_q <= degen_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign out_z      = out_z_q;
	assign out_norm_x = out_nx_q;
	assign out_norm_y = out_ny_q;
	assign out_norm_z = out_nz_q;
	assign degenerate = out_degen_q;

	// ---------------- assertions ----------------
	a_tally_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q <= TALLY_W'(MAX_VERTICES))
		else $error("vertex tally beyond limit");

	a_pass_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action) |=> in_trans_q)
		else $error("transform item did not open a pass");

	a_empty_degen: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action && !in_trans_q && (tally_q == '0)) |=> degen_q)
		else $error("empty pass not flagged degenerate");

	a_seq_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == mnp_pkg::ST_ACC) && (step_q == LAST_UOP)) |=>
			(state_q == mnp_pkg::ST_FIN))
		else $error("sequencer missed the final product");

	a_fin_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == mnp_pkg::ST_FIN) && out_free) |=> out_valid_q)
		else $error("finished result not loaded");

endmodule

[rtl/mnp_div.sv]
// ---------------------------------------------------------------------------
// mnp_div: restoring unsigned divider, one quotient bit per cycle
// Takes a request, runs DVD_W steps and pulses done with the quotient.
// ---------------------------------------------------------------------------
module mnp_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mnp_pkg::div_req_t        req,
	output logic                     done,
	output logic [mnp_pkg::DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(mnp_pkg::DVD_W);

	logic [mnp_pkg::DVS_W-1:0] rem_q;
	logic [mnp_pkg::DVD_W-1:0] quo_q;
	logic [mnp_pkg::DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [mnp_pkg::DVS_W:0]   rs;
	logic [mnp_pkg::DVS_W:0]   diff;
	logic                      ge;

	assign rs   = {rem_q, quo_q[mnp_pkg::DVD_W-1]};
	assign diff = rs - {1'b0, dvs_q};
	assign ge   = !diff[mnp_pkg::DVS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(mnp_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[mnp_pkg::DVS_W-1:0] : rs[mnp_pkg::DVS_W-1:0];
			quo_q <= {quo_q[mnp_pkg::DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
